// File: rtl/core/ljh_pkg.sv
// ----------------------------------------------------------------------------
// ljh_pkg: shared types and constants of the latency jitter histogram
// Field widths, register map, reset values and small helper functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ljh_pkg;

	localparam int TS_W        = 32;   // timestamp and delta width
	localparam int CPU_W       = 16;   // clocks_per_us width
	localparam int THR_W       = 8;    // threshold_us width
	localparam int SEC_W       = 20;   // seconds counter width
	localparam int MS_W        = 10;   // milliseconds counter width
	localparam int CNT_W       = 32;   // saturating counters and delay values
	localparam int BIN_W       = 3;    // histogram bin index
	localparam int NUM_BINS    = 6;
	localparam int MAX_EXACT_BIN = 5;
	localparam int MS_PER_S    = 1000;
	localparam int MS_LEN_W    = 26;   // clocks_per_us * 1000
	localparam int THR_TICKS_W = 24;   // threshold_us * clocks_per_us

	localparam int COUNTER_WIDTH_DEF = 32;
	localparam int QUEUE_DEPTH_DEF   = 2;

	// Register map
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_CLOCKS_PER_US = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_US  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_RUN_SECONDS   = 2'd2;

	localparam logic [CPU_W-1:0] CLOCKS_PER_US_RST = 16'd100;
	localparam logic [THR_W-1:0] THRESHOLD_US_RST  = 8'd1;
	localparam logic [SEC_W-1:0] RUN_SECONDS_RST   = 20'd10;

	typedef struct packed {
		logic [CPU_W-1:0] clocks_per_us;
		logic [THR_W-1:0] threshold_us;
		logic [SEC_W-1:0] run_seconds;
	} cfg_t;

	// One classified sample on its way from the front to the back.
	typedef struct packed {
		logic             cand;       // gap above the tick threshold
		logic [TS_W-1:0]  delta;
		logic [SEC_W-1:0] seconds;
		logic [MS_W-1:0]  ms;
		logic             run_done;
	} job_t;

	function automatic logic [CPU_W-1:0] cpu_eff(input logic [CPU_W-1:0] cpu);
		return (cpu == '0) ? CPU_W'(1) : cpu;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage

// File: rtl/core/ljh_if.sv
// ----------------------------------------------------------------------------
// ljh_if: sample and result channels of the latency jitter histogram
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ljh_sample_if;
	import ljh_pkg::*;
	logic            valid;
	logic            ready;
	logic [TS_W-1:0] timestamp;
	modport source(output valid, output timestamp, input ready);
	modport sink(input valid, input timestamp, output ready);
endinterface

interface ljh_result_if;
	import ljh_pkg::*;
	logic             valid;
	logic             ready;
	logic             delay_detected;
	logic [CNT_W-1:0] delay_us;
	logic [BIN_W-1:0] bin_index;
	logic [CNT_W-1:0] bin_count;
	logic [CNT_W-1:0] total_events;
	logic [CNT_W-1:0] max_delay_us;
	logic [SEC_W-1:0] elapsed_sec;
	logic [MS_W-1:0]  elapsed_ms;
	logic             run_done;
	modport source(output valid, output delay_detected, output delay_us, output bin_index,
		output bin_count, output total_events, output max_delay_us,
		output elapsed_sec, output elapsed_ms, output run_done, input ready);
	modport sink(input valid, input delay_detected, input delay_us, input bin_index,
		input bin_count, input total_events, input max_delay_us,
		input elapsed_sec, input elapsed_ms, input run_done, output ready);
endinterface

// File: rtl/core/ljh_front.sv
// ----------------------------------------------------------------------------
// ljh_front: sample intake and run clock
// Forms the wrapping gap, advances the ms/s run clock and flags candidates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ljh_front #(
	parameter int COUNTER_WIDTH = ljh_pkg::COUNTER_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ljh_pkg::cfg_t  cfg,
	ljh_sample_if.sink     sample,
	input  logic           q_full,
	output logic           push,
	output ljh_pkg::job_t  job
);
	import ljh_pkg::*;

	localparam int DW = (COUNTER_WIDTH > TS_W) ? TS_W : COUNTER_WIDTH;
	localparam logic [63:0] MASK64 = (64'd1 << DW) - 64'd1;
	localparam logic [TS_W-1:0] DELTA_MASK = MASK64[TS_W-1:0];

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_CALC = 2'd1;
	localparam logic [1:0] F_PUSH = 2'd2;

	logic [1:0]             state_q;
	logic [TS_W-1:0]        ts_s1;
	logic [TS_W-1:0]        delta_s2;
	logic                   upd_s2;
	logic [TS_W-1:0]        last_q;
	logic                   primed_q;
	logic [TS_W-1:0]        acc_q;
	logic [MS_W-1:0]        ms_q;
	logic [SEC_W-1:0]       sec_q;
	logic [MS_LEN_W-1:0]    ms_len_q;
	logic [THR_TICKS_W-1:0] thr_ticks_q;

	logic [TS_W-1:0]  acc_sum;
	logic             tick;
	logic [MS_W-1:0]  ms_inc;
	logic             ms_wrap;
	logic [TS_W-1:0]  acc_nxt;
	logic [MS_W-1:0]  ms_nxt;
	logic [SEC_W-1:0] sec_nxt;
	logic             active;

	assign active  = sec_q < cfg.run_seconds;
	assign acc_sum = acc_q + delta_s2;
	assign tick    = acc_sum > TS_W'(ms_len_q);
	assign ms_inc  = ms_q + MS_W'(1);
	assign ms_wrap = ms_inc >= MS_W'(MS_PER_S);

	always_comb begin
		acc_nxt = acc_q;
		ms_nxt  = ms_q;
		sec_nxt = sec_q;
		if (upd_s2) begin
			if (tick) begin
				acc_nxt = '0;
				if (ms_wrap) begin
					ms_nxt  = '0;
					sec_nxt = sec_q + SEC_W'(1);
				end else begin
					ms_nxt = ms_inc;
				end
			end else begin
				acc_nxt = acc_sum;
			end
		end
	end

	assign sample.ready = (state_q == F_IDLE) && !q_full;
	assign push         = (state_q == F_PUSH);

	assign job.cand     = upd_s2 && (delta_s2 > TS_W'(thr_ticks_q));
	assign job.delta    = delta_s2;
	assign job.seconds  = sec_nxt;
	assign job.ms       = ms_nxt;
	assign job.run_done = sec_nxt >= cfg.run_seconds;

	// Config tick limits; user must change config only while idle, not checked.
	always_ff @(posedge clk) begin
		ms_len_q    <= MS_LEN_W'(cpu_eff(cfg.clocks_per_us)) * MS_LEN_W'(MS_PER_S);
		thr_ticks_q <= THR_TICKS_W'(cfg.threshold_us) * THR_TICKS_W'(cpu_eff(cfg.clocks_per_us));
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && sample.valid && sample.ready) begin
			ts_s1 <= sample.timestamp;
		end
		if (state_q == F_CALC) begin
			delta_s2 <= (ts_s1 - last_q) & DELTA_MASK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			upd_s2   <= 1'b0;
			last_q   <= '0;
			primed_q <= 1'b0;
			acc_q    <= '0;
			ms_q     <= '0;
			sec_q    <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (sample.valid && sample.ready) begin
						state_q <= F_CALC;
					end
				end
				F_CALC: begin
					upd_s2 <= active && primed_q;
					if (active) begin
						primed_q <= 1'b1;
						last_q   <= ts_s1;
					end
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					acc_q   <= acc_nxt;
					ms_q    <= ms_nxt;
					sec_q   <= sec_nxt;
					state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/ljh_queue.sv
// ----------------------------------------------------------------------------
// ljh_queue: short job queue between front and back
// Small first-in first-out buffer of classified samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ljh_queue #(
	parameter int DEPTH = ljh_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ljh_pkg::job_t wr_data,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output ljh_pkg::job_t rd_data
);
	import ljh_pkg::*;

	// DEPTH is a power of two, at least two.
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = count_q == CW'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if ((push && !full) && !(pop && !empty)) begin
				count_q <= count_q + CW'(1);
			end else if (!(push && !full) && (pop && !empty)) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/core/ljh_divider.sv
// ----------------------------------------------------------------------------
// ljh_divider: iterative unsigned divider
// Restoring division of the gap by ticks per microsecond, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ljh_divider (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ljh_pkg::TS_W-1:0]   dividend,
	input  logic [ljh_pkg::CPU_W-1:0]  divisor,
	output logic                       done,
	output logic [ljh_pkg::TS_W-1:0]   quotient
);
	import ljh_pkg::*;

	localparam int IW = $clog2(TS_W);

	logic [CPU_W-1:0] rem_q;
	logic [TS_W-1:0]  quo_q;
	logic [CPU_W-1:0] div_q;
	logic [IW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [CPU_W:0] trial;
	logic [CPU_W:0] diff;
	logic           ge;

	assign trial    = {rem_q, quo_q[TS_W-1]};
	assign diff     = trial - {1'b0, div_q};
	assign ge       = trial >= {1'b0, div_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CPU_W-1:0] : trial[CPU_W-1:0];
			quo_q <= {quo_q[TS_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + IW'(1);
				if (cnt_q == IW'(TS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/core/ljh_back.sv
// ----------------------------------------------------------------------------
// ljh_back: delay measurement and histogram update
// Divides candidate gaps, updates bins, total and peak, holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ljh_back (
	input  logic          clk,
	input  logic          arst_n,
	input  ljh_pkg::cfg_t cfg,
	input  logic          q_empty,
	output logic          pop,
	input  ljh_pkg::job_t job_in,
	ljh_result_if.source  result
);
	import ljh_pkg::*;

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_DIV  = 2'd1;
	localparam logic [1:0] B_OUT  = 2'd2;

	logic [1:0]       state_q;
	job_t             job_q;
	logic [CNT_W-1:0] quot_q;
	logic [CNT_W-1:0] bins_q [NUM_BINS];
	logic [CNT_W-1:0] total_q;
	logic [CNT_W-1:0] peak_q;
	logic             out_valid_q;
	logic             det_q;
	logic [CNT_W-1:0] dly_q;
	logic [BIN_W-1:0] bin_q;
	logic [CNT_W-1:0] bcnt_q;
	logic [SEC_W-1:0] sec_q;
	logic [MS_W-1:0]  ms_q;
	logic             run_done_q;

	logic             div_start;
	logic             div_done;
	logic [TS_W-1:0]  div_quot;
	logic             load;
	logic             ev;
	logic [BIN_W-1:0] bin_sel;
	logic [CNT_W-1:0] cnt_nxt;

	assign pop       = (state_q == B_IDLE) && !q_empty;
	assign div_start = pop && job_in.cand;
	assign load      = (state_q == B_OUT) && (!out_valid_q || result.ready);

	// A zero quotient never counts, which only happens with a zero threshold.
	assign ev      = job_q.cand && (quot_q != '0);
	assign bin_sel = (quot_q <= CNT_W'(MAX_EXACT_BIN)) ? quot_q[BIN_W-1:0] : '0;
	assign cnt_nxt = sat_inc(bins_q[bin_sel]);

	ljh_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (job_in.delta),
		.divisor  (cpu_eff(cfg.clocks_per_us)),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign result.valid           = out_valid_q;
	assign result.delay_detected  = det_q;
	assign result.delay_us        = dly_q;
	assign result.bin_index       = bin_q;
	assign result.bin_count       = bcnt_q;
	assign result.total_events    = total_q;
	assign result.max_delay_us    = peak_q;
	assign result.elapsed_sec     = sec_q;
	assign result.elapsed_ms      = ms_q;
	assign result.run_done        = run_done_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job_in;
		end
		if (pop) begin
			quot_q <= '0;
		end else if (state_q == B_DIV && div_done) begin
			quot_q <= CNT_W'(div_quot);
		end
		if (load) begin
			det_q      <= ev;
			dly_q      <= ev ? quot_q : '0;
			bin_q      <= ev ? bin_sel : '0;
			bcnt_q     <= ev ? cnt_nxt : '0;
			sec_q      <= job_q.seconds;
			ms_q       <= job_q.ms;
			run_done_q <= job_q.run_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			total_q     <= '0;
			peak_q      <= '0;
			for (int i = 0; i < NUM_BINS; i++) begin
				bins_q[i] <= '0;
			end
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load && ev) begin
				bins_q[bin_sel] <= cnt_nxt;
				total_q         <= sat_inc(total_q);
				if (quot_q > peak_q) begin
					peak_q <= quot_q;
				end
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						state_q <= job_in.cand ? B_DIV : B_OUT;
					end
				end
				B_DIV: begin
					if (div_done) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (load) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/core/latency_jitter_histogram.sv
// ----------------------------------------------------------------------------
// latency_jitter_histogram: gap histogram over a free-running tick counter
// Measures gaps between timestamp samples, runs a ms/s clock and keeps a
// saturating histogram, total and peak of delays in microseconds.
// ----------------------------------------------------------------------------
//
//   channel   direction  payload                                 handshake
//   sample    in         timestamp                               valid/ready
//   result    out        delay and histogram status, one a word  valid/ready
//   config    in/out     clocks_per_us, threshold_us, run_secs   APB, pready = 1
//
// In the front a sample word passes the capture, gap and run-clock states in
// turn. A word whose gap is above the tick threshold then holds the back
// while the 32-step divider runs; any other word goes to the result load.
// Reset is asynchronous and clears all counters, the histogram and the queue.
// The queue lets the front take new words while the back divides or while a
// result word waits on a stalled sink; the back loads a new result word only
// when the result register is empty or the sink takes its word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module latency_jitter_histogram #(
	parameter int COUNTER_WIDTH = ljh_pkg::COUNTER_WIDTH_DEF,
	parameter int QUEUE_DEPTH   = ljh_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ljh_sample_if.sink                    sample,
	ljh_result_if.source                  result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ljh_pkg::PADDR_W-1:0]   paddr,
	input  logic [ljh_pkg::PDATA_W-1:0]   pwdata,
	output logic [ljh_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import ljh_pkg::*;

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	logic q_full;
	logic q_empty;
	logic push;
	logic pop;
	job_t job_wr;
	job_t job_rd;

	// Registers sit on word addresses; the low two address bits are ignored.
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clocks_per_us <= CLOCKS_PER_US_RST;
			cfg_q.threshold_us  <= THRESHOLD_US_RST;
			cfg_q.run_seconds   <= RUN_SECONDS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CLOCKS_PER_US: cfg_q.clocks_per_us <= pwdata[CPU_W-1:0];
				REG_THRESHOLD_US:  cfg_q.threshold_us  <= pwdata[THR_W-1:0];
				REG_RUN_SECONDS:   cfg_q.run_seconds   <= pwdata[SEC_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CLOCKS_PER_US: prdata = PDATA_W'(cfg_q.clocks_per_us);
			REG_THRESHOLD_US:  prdata = PDATA_W'(cfg_q.threshold_us);
			REG_RUN_SECONDS:   prdata = PDATA_W'(cfg_q.run_seconds);
			default:           prdata = '0;
		endcase
	end

	// Front: takes samples, forms gaps and keeps the run clock.
	ljh_front #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.sample (sample),
		.q_full (q_full),
		.push   (push),
		.job    (job_wr)
	);

	ljh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (job_wr),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.rd_data (job_rd)
	);

	// Back: divides the gap, updates the histogram and drives results.
	ljh_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.pop     (pop),
		.job_in  (job_rd),
		.result  (result)
	);

endmodule
